// ----- rtl/hal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_pkg
// Shared types and constants of the hashed allocation leak tracker.
// ----------------------------------------------------------------------------
package hal_pkg;

    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 32;
    localparam int HASH_W    = 32;
    localparam int OUT_IDX_W = 16;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } t_state;

    typedef enum logic [3:0] {
        H_IDLE,
        H_MUL_LO,
        H_MUL_HI,
        H_FOLD,
        H_MIX,
        H_QUOT,
        H_BACK,
        H_FIX,
        H_DONE
    } t_hash_state;

endpackage

// ----- rtl/hal_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_mem
// Bucket counter store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hal_mem #(
    parameter int DEPTH = 65521,
    parameter int WIDTH = 80,
    parameter int AW    = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/hal_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hal_hash
// Bucket hash: one shared 32x32 multiplier for the three hash products, then
// a reciprocal quotient estimate, its back-multiply and one correcting step.
// ----------------------------------------------------------------------------
module hal_hash #(
    parameter int BUCKETS = 65521,
    parameter int IDX_W   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hal_pkg::ADDR_W-1:0]  i_addr,
    input  logic [hal_pkg::SIZE_W-1:0]  i_size,
    output logic                        o_done,
    output logic [IDX_W-1:0]            o_idx
);

    // floor(2^32 / BUCKETS) never overestimates the quotient and misses it by
    // at most one, so a single compare and subtract finishes the remainder.
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

    hal_pkg::t_hash_state r_state, n_state;

    logic [hal_pkg::ADDR_W-1:0] r_addr;
    logic [hal_pkg::SIZE_W-1:0] r_size;
    logic [63:0]                r_prod, n_prod;
    logic [63:0]                r_p_lo, n_p_lo;
    logic [hal_pkg::HASH_W-1:0] r_v, n_v;
    logic [IDX_W-1:0]           r_rem, n_rem;

    logic [31:0]     w_mul_a;
    logic [31:0]     w_mul_b;
    logic [63:0]     w_mul_p;
    logic [31:0]     w_rem_est;
    logic [31:0]     w_rem_sub;
    logic            w_ge;

    assign w_mul_p   = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_rem_est = r_v - r_prod[31:0];
    assign w_ge      = (w_rem_est >= 32'(BUCKETS));
    assign w_rem_sub = w_rem_est - 32'(BUCKETS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hal_pkg::H_IDLE: begin
                if (i_start) begin
                    n_state = hal_pkg::H_MUL_LO;
                end
            end
            hal_pkg::H_MUL_LO: n_state = hal_pkg::H_MUL_HI;
            hal_pkg::H_MUL_HI: n_state = hal_pkg::H_FOLD;
            hal_pkg::H_FOLD:   n_state = hal_pkg::H_MIX;
            hal_pkg::H_MIX:    n_state = hal_pkg::H_QUOT;
            hal_pkg::H_QUOT:   n_state = hal_pkg::H_BACK;
            hal_pkg::H_BACK:   n_state = hal_pkg::H_FIX;
            hal_pkg::H_FIX:    n_state = hal_pkg::H_DONE;
            hal_pkg::H_DONE:   n_state = hal_pkg::H_IDLE;
            default:           n_state = hal_pkg::H_IDLE;
        endcase
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        n_prod  = r_prod;
        n_p_lo  = r_p_lo;
        n_v     = r_v;
        n_rem   = r_rem;
        o_done  = 1'b0;
        case (r_state)
            hal_pkg::H_MUL_LO: begin
                w_mul_a = r_addr[31:0];
                w_mul_b = r_size;
                n_prod  = w_mul_p;
            end
            hal_pkg::H_MUL_HI: begin
                w_mul_a = r_addr[63:32];
                w_mul_b = r_size;
                n_p_lo  = r_prod;
                n_prod  = w_mul_p;
            end
            hal_pkg::H_FOLD: begin
                // Only the low half of the upper cross product reaches bit 63.
                n_v = r_p_lo[31:0] ^ (r_p_lo[63:32] + r_prod[31:0]);
            end
            hal_pkg::H_MIX: begin
                w_mul_a = r_v;
                w_mul_b = hal_pkg::HASH_MULT;
                n_prod  = w_mul_p;
            end
            hal_pkg::H_QUOT: begin
                // Keep the mixed hash for the final subtract.
                n_v     = r_prod[31:0];
                w_mul_a = r_prod[31:0];
                w_mul_b = RECIP;
                n_prod  = w_mul_p;
            end
            hal_pkg::H_BACK: begin
                w_mul_a = r_prod[63:32];
                w_mul_b = 32'(BUCKETS);
                n_prod  = w_mul_p;
            end
            hal_pkg::H_FIX: begin
                n_rem = w_ge ? w_rem_sub[IDX_W-1:0] : w_rem_est[IDX_W-1:0];
            end
            hal_pkg::H_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hal_pkg::H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hal_pkg::H_IDLE && i_start) begin
            r_addr <= i_addr;
            r_size <= i_size;
        end
        r_prod <= n_prod;
        r_p_lo <= n_p_lo;
        r_v    <= n_v;
        r_rem  <= n_rem;
    end

    assign o_idx = r_rem;

endmodule

// ----- rtl/hashed_allocation_leak_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_allocation_leak_tracker
// Per-bucket block and byte counters for allocate and free events, with a
// sticky warning for unbalanced frees and a leak check over all buckets.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to zero, one bucket per
// cycle, and holds busy high until the sweep is done. An allocate or free
// with a nonzero address then runs from its transfer to its result strobe
// through the hash steps on one shared 32x32 multiplier (the address-size
// product in low and high halves, a fold, the fingerprint mix, a
// reciprocal quotient estimate by BUCKETS, its back-multiply and one
// correcting subtract), a handoff state, a read, update and write of the
// bucket's memory word, and the strobe cycle, in which the next item can
// already be transferred. A check, a zero address or an unused operation
// code gives its result in the cycle after the transfer and can be followed
// by another item at once, since the leak check reads a running count of
// nonzero buckets. Each result is shown for one cycle on o_valid and cannot
// be held off by the receiver.
// ----------------------------------------------------------------------------
module hashed_allocation_leak_tracker #(
    parameter int BUCKETS           = 65521,
    parameter int BLOCK_COUNT_WIDTH = 32,
    parameter int BYTE_COUNT_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [hal_pkg::ADDR_W-1:0]     i_block_address,
    input  logic [hal_pkg::SIZE_W-1:0]     i_block_size,
    output logic                           o_valid,
    output logic [hal_pkg::OUT_IDX_W-1:0]  o_bucket_index,
    output logic                           o_ignored,
    output logic                           o_unbalanced_free,
    output logic                           o_warned,
    output logic                           o_clean
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int NZ_W  = $clog2(BUCKETS + 1);
    localparam int BLK_W = BLOCK_COUNT_WIDTH;
    localparam int BYT_W = BYTE_COUNT_WIDTH;
    localparam int MEM_W = BLK_W + BYT_W;
    localparam int CMP_W = (BYT_W > hal_pkg::SIZE_W) ? BYT_W : hal_pkg::SIZE_W;

    hal_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0] r_clr, n_clr;
    logic [NZ_W-1:0]  r_nz, n_nz;
    logic             r_warn, n_warn;
    logic             r_valid, n_valid;

    hal_pkg::t_op              r_op, n_op;
    logic [hal_pkg::SIZE_W-1:0] r_size, n_size;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [BLK_W-1:0]          r_new_blk, n_new_blk;
    logic [BYT_W-1:0]          r_new_byt, n_new_byt;
    logic                      r_old_nz, n_old_nz;
    logic                      r_new_nz, n_new_nz;
    logic                      r_unbal, n_unbal;
    logic [hal_pkg::OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic                      r_out_ign, n_out_ign;
    logic                      r_out_unbal, n_out_unbal;
    logic                      r_out_clean, n_out_clean;

    logic             w_accept;
    logic             w_needs_hash;
    logic             w_hash_done;
    logic [IDX_W-1:0] w_hash_idx;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [MEM_W-1:0] w_wdata;
    logic [MEM_W-1:0] w_rdata;
    logic [BLK_W-1:0] w_rd_blk;
    logic [BYT_W-1:0] w_rd_byt;
    logic [CMP_W-1:0] w_byt_ext;
    logic [CMP_W-1:0] w_size_ext;
    logic [CMP_W-1:0] w_byt_sum;
    logic [CMP_W-1:0] w_byt_dif;
    logic [BLK_W-1:0] w_blk_new;
    logic [BYT_W-1:0] w_byt_new;

    assign busy     = (r_state != hal_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_needs_hash = ((i_operation == hal_pkg::OP_ALLOC) ||
                           (i_operation == hal_pkg::OP_FREE)) &&
                          (i_block_address != '0);

    hal_hash #(
        .BUCKETS (BUCKETS),
        .IDX_W   (IDX_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_needs_hash),
        .i_addr  (i_block_address),
        .i_size  (i_block_size),
        .o_done  (w_hash_done),
        .o_idx   (w_hash_idx)
    );

    hal_mem #(
        .DEPTH (BUCKETS),
        .WIDTH (MEM_W),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_blk   = w_rdata[BYT_W +: BLK_W];
    assign w_rd_byt   = w_rdata[BYT_W-1:0];
    assign w_byt_ext  = CMP_W'(w_rd_byt);
    assign w_size_ext = CMP_W'(r_size);
    assign w_byt_sum  = w_byt_ext + w_size_ext;
    assign w_byt_dif  = w_byt_ext - w_size_ext;
    assign w_blk_new  = (r_op == hal_pkg::OP_ALLOC) ? (w_rd_blk + BLK_W'(1))
                                                    : (w_rd_blk - BLK_W'(1));
    assign w_byt_new  = (r_op == hal_pkg::OP_ALLOC) ? w_byt_sum[BYT_W-1:0]
                                                    : w_byt_dif[BYT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            hal_pkg::ST_CLEAR: begin
                if (r_clr == IDX_W'(BUCKETS - 1)) begin
                    n_state = hal_pkg::ST_IDLE;
                end
            end
            hal_pkg::ST_IDLE: begin
                if (w_accept && w_needs_hash) begin
                    n_state = hal_pkg::ST_HASH;
                end
            end
            hal_pkg::ST_HASH: begin
                if (w_hash_done) begin
                    n_state = hal_pkg::ST_READ;
                end
            end
            hal_pkg::ST_READ:  n_state = hal_pkg::ST_CALC;
            hal_pkg::ST_CALC:  n_state = hal_pkg::ST_WRITE;
            hal_pkg::ST_WRITE: n_state = hal_pkg::ST_IDLE;
            default:           n_state = hal_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        n_clr       = r_clr;
        n_nz        = r_nz;
        n_warn      = r_warn;
        n_valid     = 1'b0;
        n_op        = r_op;
        n_size      = r_size;
        n_idx       = r_idx;
        n_new_blk   = r_new_blk;
        n_new_byt   = r_new_byt;
        n_old_nz    = r_old_nz;
        n_new_nz    = r_new_nz;
        n_unbal     = r_unbal;
        n_out_idx   = r_out_idx;
        n_out_ign   = r_out_ign;
        n_out_unbal = r_out_unbal;
        n_out_clean = r_out_clean;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {r_new_blk, r_new_byt};
        case (r_state)
            hal_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + IDX_W'(1);
            end
            hal_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op        = hal_pkg::t_op'(i_operation);
                    n_size      = i_block_size;
                    n_out_idx   = '0;
                    n_out_ign   = 1'b0;
                    n_out_unbal = 1'b0;
                    n_out_clean = 1'b0;
                    case (hal_pkg::t_op'(i_operation))
                        hal_pkg::OP_ALLOC, hal_pkg::OP_FREE: begin
                            if (i_block_address == '0) begin
                                n_valid   = 1'b1;
                                n_out_ign = 1'b1;
                            end
                        end
                        hal_pkg::OP_CHECK: begin
                            n_valid     = 1'b1;
                            n_out_clean = (r_nz == '0) && !r_warn;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            hal_pkg::ST_HASH: begin
                if (w_hash_done) begin
                    n_idx = w_hash_idx;
                end
            end
            hal_pkg::ST_CALC: begin
                n_new_blk = w_blk_new;
                n_new_byt = w_byt_new;
                n_old_nz  = (w_rd_blk != '0) || (w_rd_byt != '0);
                n_new_nz  = (w_blk_new != '0) || (w_byt_new != '0);
                n_unbal   = (r_op == hal_pkg::OP_FREE) &&
                            ((w_rd_blk == '0) || (w_byt_ext < w_size_ext));
            end
            hal_pkg::ST_WRITE: begin
                w_we        = 1'b1;
                n_warn      = r_warn || r_unbal;
                n_valid     = 1'b1;
                n_out_idx   = hal_pkg::OUT_IDX_W'(r_idx);
                n_out_ign   = 1'b0;
                n_out_unbal = r_unbal;
                n_out_clean = 1'b0;
                // Keep a live count of buckets holding anything, for the check.
                if (!r_old_nz && r_new_nz) begin
                    n_nz = r_nz + NZ_W'(1);
                end else if (r_old_nz && !r_new_nz) begin
                    n_nz = r_nz - NZ_W'(1);
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hal_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_nz    <= '0;
            r_warn  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_nz    <= n_nz;
            r_warn  <= n_warn;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_size      <= n_size;
        r_idx       <= n_idx;
        r_new_blk   <= n_new_blk;
        r_new_byt   <= n_new_byt;
        r_old_nz    <= n_old_nz;
        r_new_nz    <= n_new_nz;
        r_unbal     <= n_unbal;
        r_out_idx   <= n_out_idx;
        r_out_ign   <= n_out_ign;
        r_out_unbal <= n_out_unbal;
        r_out_clean <= n_out_clean;
    end

    assign o_valid           = r_valid;
    assign o_bucket_index    = r_out_idx;
    assign o_ignored         = r_out_ign;
    assign o_unbalanced_free = r_out_unbal;
    assign o_warned          = r_warn;
    assign o_clean           = r_out_clean;

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_valid))
        else $error("transfer neither started work nor gave a result");

    a_hash_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> (r_state == hal_pkg::ST_HASH))
        else $error("hash finished outside the hash wait state");

    a_unbal_warns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unbalanced_free) |-> o_warned)
        else $error("unbalanced free without sticky warning");

    a_clean_no_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clean) |-> (!o_warned && !o_ignored && o_bucket_index == '0))
        else $error("clean result with warning or bucket set");

    a_nz_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nz <= NZ_W'(BUCKETS))
        else $error("nonzero bucket count beyond bucket total");

endmodule
